### rtl/fpe_pkg.sv
package fpe_pkg;

    // Input operation codes.
    localparam logic [1:0] FUNC_DRAW = 2'd0;
    localparam logic [1:0] FUNC_FILL = 2'd1;
    localparam logic [1:0] FUNC_TILE = 2'd2;

    // Result kinds: command byte or display data byte.
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // Panel command bytes.
    localparam logic [7:0] PAGE_CMD     = 8'hB0;
    localparam logic [7:0] HIGH_COL_CMD = 8'h10;
    localparam logic [7:0] FILL_ONES    = 8'hFF;
    localparam logic [7:0] FILL_ZEROS   = 8'h00;

    // A page index needs at most four bits (up to 16 pages).
    localparam int PAGE_W = 4;

    // One bus write toward the panel.
    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
    } t_result;

endpackage

### rtl/fpe_mem.sv
module fpe_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; the output holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/fpe_obuf.sv
module fpe_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fpe_pkg::t_result i_data,
    output logic             o_can_push,
    output logic             o_valid,
    output fpe_pkg::t_result o_data,
    input  logic             i_stall
);
    import fpe_pkg::*;

    t_result    r_data [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;

    // Two entries keep the sequencer running while the consumer stalls.
    assign o_can_push = (r_count != 2'd2);
    assign o_valid    = (r_count != 2'd0);
    assign o_data     = r_data[r_rd_ptr];
    assign w_pop      = o_valid && !i_stall;

    // Pointer and occupancy bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/fpe_ctrl.sv
module fpe_ctrl #(
    parameter int PANEL_COLUMNS = 128,
    parameter int PANEL_PAGES   = 8,
    parameter int TILE_COLUMNS  = 32,
    parameter int DEPTH         = 1024,
    parameter int AW            = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Configuration.
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    // Input item.
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_func,
    input  logic [7:0]       i_pos_x,
    input  logic [7:0]       i_pos_y,
    input  logic             i_color,
    input  logic [2:0]       i_tile_page,
    input  logic [1:0]       i_tile_column,
    // Frame memory.
    output logic             o_wr_en,
    output logic [AW-1:0]    o_wr_addr,
    output logic [7:0]       o_wr_data,
    output logic             o_rd_en,
    output logic [AW-1:0]    o_rd_addr,
    input  logic [7:0]       i_rd_data,
    // Result buffer.
    output logic             o_push,
    output fpe_pkg::t_result o_result,
    input  logic             i_can_push
);
    import fpe_pkg::*;

    localparam int TCW = $clog2(TILE_COLUMNS + 1);

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_PIX,
        S_CMD,
        S_DATA,
        S_TILE
    } t_state;

    t_state              r_state, n_state;
    logic                r_incr, n_incr;
    logic [PAGE_W-1:0]   r_page, n_page;
    logic [7:0]          r_col, n_col;
    logic [7:0]          r_byte, n_byte;
    logic [7:0]          r_mask, n_mask;
    logic                r_color, n_color;
    logic [7:0]          r_fill_byte, n_fill_byte;
    logic [AW-1:0]       r_addr, n_addr;
    logic [1:0]          r_cnt, n_cnt;
    logic [TCW-1:0]      r_rd_cnt, n_rd_cnt;
    logic                r_pending, n_pending;
    logic                r_is_tile, n_is_tile;

    logic                w_pix_ok;
    logic                w_tile_ok;
    logic [4:0]          w_pix_page;
    logic [AW-1:0]       w_pix_addr;
    logic [9:0]          w_tile_start;
    logic [AW-1:0]       w_tile_addr;
    logic [7:0]          w_new_byte;
    logic                w_issue;

    // Pixel clipping and its buffer address.
    assign w_pix_page = i_pos_y[7:3];
    assign w_pix_ok   = (9'(i_pos_x) < 9'(PANEL_COLUMNS))
                     && (9'(i_pos_y) < 9'(8 * PANEL_PAGES));
    assign w_pix_addr = AW'(32'(w_pix_page) * 32'(PANEL_COLUMNS) + 32'(i_pos_x));

    // Tile bounds and the address of its first column.
    assign w_tile_start = 10'(i_tile_column) * 10'(TILE_COLUMNS);
    assign w_tile_ok    = (5'(i_tile_page) < 5'(PANEL_PAGES))
                       && ((w_tile_start + 10'(TILE_COLUMNS)) <= 10'(PANEL_COLUMNS));
    assign w_tile_addr  = AW'(32'(i_tile_page) * 32'(PANEL_COLUMNS) + 32'(w_tile_start));

    // Read-modify-write of the addressed byte.
    assign w_new_byte = r_color ? (i_rd_data | r_mask) : (i_rd_data & ~r_mask);

    // A tile read is issued when the previous byte is gone or leaves now.
    assign w_issue = (r_state == S_TILE) && (r_rd_cnt != TCW'(TILE_COLUMNS))
                  && (!r_pending || i_can_push);

    assign o_in_stall = (r_state != S_IDLE);

    // Next-state logic and the memory and result buffer strobes.
    always_comb begin
        n_state     = r_state;
        n_incr      = r_incr;
        n_page      = r_page;
        n_col       = r_col;
        n_byte      = r_byte;
        n_mask      = r_mask;
        n_color     = r_color;
        n_fill_byte = r_fill_byte;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_rd_cnt    = r_rd_cnt;
        n_pending   = r_pending;
        n_is_tile   = r_is_tile;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_addr;
        o_wr_data   = r_fill_byte;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_addr;
        o_push      = 1'b0;
        o_result    = '{kind: KIND_CMD, value: 8'h00, last: 1'b0};

        if (i_cfg_wr_en) begin
            n_incr = i_cfg_wr_data;
        end

        case (r_state)
            S_FILL: begin
                o_wr_en = 1'b1;
                n_addr  = r_addr + AW'(1);
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_func)
                        FUNC_DRAW: begin
                            if (w_pix_ok) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = w_pix_addr;
                                n_addr    = w_pix_addr;
                                n_page    = w_pix_page[PAGE_W-1:0];
                                n_col     = i_pos_x;
                                n_mask    = 8'd1 << i_pos_y[2:0];
                                n_color   = i_color;
                                n_state   = S_PIX;
                            end
                        end
                        FUNC_FILL: begin
                            n_fill_byte = i_color ? FILL_ONES : FILL_ZEROS;
                            n_addr      = '0;
                            n_state     = S_FILL;
                        end
                        FUNC_TILE: begin
                            if (w_tile_ok) begin
                                n_addr    = w_tile_addr;
                                n_page    = PAGE_W'(i_tile_page);
                                n_col     = w_tile_start[7:0];
                                n_cnt     = 2'd0;
                                n_rd_cnt  = '0;
                                n_pending = 1'b0;
                                n_is_tile = 1'b1;
                                n_state   = S_CMD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PIX: begin
                o_wr_en   = 1'b1;
                o_wr_data = w_new_byte;
                n_byte    = w_new_byte;
                n_cnt     = 2'd0;
                n_is_tile = 1'b0;
                n_state   = r_incr ? S_CMD : S_IDLE;
            end
            S_CMD: begin
                o_push = i_can_push;
                case (r_cnt)
                    2'd0:    o_result.value = PAGE_CMD + 8'(r_page);
                    2'd1:    o_result.value = {4'h0, r_col[3:0]};
                    default: o_result.value = HIGH_COL_CMD + {4'h0, r_col[7:4]};
                endcase
                if (i_can_push) begin
                    n_cnt = r_cnt + 2'd1;
                    if (r_cnt == 2'd2) begin
                        n_state = r_is_tile ? S_TILE : S_DATA;
                    end
                end
            end
            S_DATA: begin
                o_push   = i_can_push;
                o_result = '{kind: KIND_DATA, value: r_byte, last: 1'b1};
                if (i_can_push) begin
                    n_state = S_IDLE;
                end
            end
            S_TILE: begin
                // Streams one byte a cycle while the result buffer has room; the memory output holds a byte
                // that the result buffer cannot take yet.
                o_push   = r_pending && i_can_push;
                o_result = '{kind: KIND_DATA, value: i_rd_data,
                             last: (r_rd_cnt == TCW'(TILE_COLUMNS))};
                o_rd_en  = w_issue;
                if (w_issue) begin
                    n_addr   = r_addr + AW'(1);
                    n_rd_cnt = r_rd_cnt + TCW'(1);
                end
                n_pending = w_issue || (r_pending && !i_can_push);
                if (o_push && (r_rd_cnt == TCW'(TILE_COLUMNS))) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_incr      <= 1'b1;
            r_addr      <= '0;
            r_fill_byte <= FILL_ZEROS;
            r_cnt       <= 2'd0;
            r_rd_cnt    <= '0;
            r_pending   <= 1'b0;
            r_is_tile   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_incr      <= n_incr;
            r_addr      <= n_addr;
            r_fill_byte <= n_fill_byte;
            r_cnt       <= n_cnt;
            r_rd_cnt    <= n_rd_cnt;
            r_pending   <= n_pending;
            r_is_tile   <= n_is_tile;
        end
        r_page  <= n_page;
        r_col   <= n_col;
        r_byte  <= n_byte;
        r_mask  <= n_mask;
        r_color <= n_color;
    end

    // The memory has one read and one write port, never both used at once here.
    a_no_rd_wr_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_wr_en && o_rd_en))
        else $error("frame memory read and write in the same cycle");

    // A result is only handed over when the buffer has room.
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_can_push)
        else $error("result pushed into a full buffer");

    // A drawn pixel is written back on the cycle after its read.
    a_pix_writeback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_func == FUNC_DRAW && w_pix_ok)
        |=> (r_state == S_PIX && o_wr_en && o_wr_addr == $past(w_pix_addr)))
        else $error("pixel write-back missing or misaddressed");

    // A tile never reads past its last column.
    a_tile_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TILE) |-> (r_rd_cnt <= TCW'(TILE_COLUMNS)))
        else $error("tile read count overrun");

endmodule

### rtl/page_framebuffer_pixel_engine_core.sv
// Page-addressed monochrome frame buffer engine. The buffer holds
// PANEL_COLUMNS x 8*PANEL_PAGES pixels in a single-port-read, single-port-write
// synchronous memory of PANEL_COLUMNS*PANEL_PAGES bytes, one bit per row.
// After reset the block clears the memory, one byte a cycle, and takes no item
// until the clear is done; configuration writes are taken throughout. Every
// item is handled by a read-modify-write sequencer around that memory, one
// item at a time. A pixel draw reads the byte and writes it back; with
// incremental update it then sends three command bytes and one data byte,
// one result byte per cycle while the result buffer has room. A fill writes
// one byte per cycle over the whole memory. A tile refresh sends three
// command bytes, then the data bytes stream one per cycle out of the memory
// read port while the result buffer has room. Clipped pixels, unused
// operations and tiles outside the panel are dropped without output. A
// two-entry result buffer lets the next item be taken while results still
// wait.
module page_framebuffer_pixel_engine_core #(
    parameter int PANEL_COLUMNS = 128,
    parameter int PANEL_PAGES   = 8,
    parameter int TILE_COLUMNS  = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration write.
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    // Input channel.
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_func,
    input  logic [7:0] i_pos_x,
    input  logic [7:0] i_pos_y,
    input  logic       i_color,
    input  logic [2:0] i_tile_page,
    input  logic [1:0] i_tile_column,
    // Output channel.
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_kind,
    output logic [7:0] o_value,
    output logic       o_last
);
    import fpe_pkg::*;

    localparam int DEPTH = PANEL_COLUMNS * PANEL_PAGES;
    localparam int AW    = $clog2(DEPTH);

    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [7:0]    w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]    w_rd_data;
    logic          w_push;
    logic          w_can_push;
    t_result       w_result;
    t_result       w_out;

    // Sequencer.
    fpe_ctrl #(
        .PANEL_COLUMNS (PANEL_COLUMNS),
        .PANEL_PAGES   (PANEL_PAGES),
        .TILE_COLUMNS  (TILE_COLUMNS),
        .DEPTH         (DEPTH),
        .AW            (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_color       (i_color),
        .i_tile_page   (i_tile_page),
        .i_tile_column (i_tile_column),
        .o_wr_en       (w_wr_en),
        .o_wr_addr     (w_wr_addr),
        .o_wr_data     (w_wr_data),
        .o_rd_en       (w_rd_en),
        .o_rd_addr     (w_rd_addr),
        .i_rd_data     (w_rd_data),
        .o_push        (w_push),
        .o_result      (w_result),
        .i_can_push    (w_can_push)
    );

    // Frame memory.
    fpe_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Result buffer toward the panel bus.
    fpe_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_data     (w_result),
        .o_can_push (w_can_push),
        .o_valid    (o_out_valid),
        .o_data     (w_out),
        .i_stall    (i_out_stall)
    );

    assign o_kind  = w_out.kind;
    assign o_value = w_out.value;
    assign o_last  = w_out.last;

endmodule

### tb/page_framebuffer_pixel_engine_core_tb.sv
`timescale 1ns / 100ps

module page_framebuffer_pixel_engine_core_tb;

    import fpe_pkg::*;

    localparam int COLS  = 128;
    localparam int PAGES = 8;
    localparam int TILE  = 32;

    // The only operation code the package does not name.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // A fill walks the whole buffer, so an idle block may still be busy this long.
    localparam int QUIET_CYCLES = COLS * PAGES + 64;
    localparam int TAIL_CYCLES  = 64;
    localparam int LIMIT_CYCLES = 400000;

    // Tracks the panel contents and the bus writes still owed by the block.
    class panel_write_board;
        logic [7:0] shadow [COLS * PAGES];
        bit         incremental;
        t_result    pending_writes [$];
        int         errors;
        int         checked;

        function new();
            foreach (shadow[i]) shadow[i] = FILL_ZEROS;
            incremental = 1'b1;
            errors      = 0;
            checked     = 0;
        endfunction

        function void push_write(logic kind, logic [7:0] value, logic last);
            t_result w;
            w.kind  = kind;
            w.value = value;
            w.last  = last;
            pending_writes.push_back(w);
        endfunction

        // Page command followed by the low and high column commands.
        function void push_address(int page, int col);
            push_write(KIND_CMD, PAGE_CMD + 8'(page), 1'b0);
            push_write(KIND_CMD, 8'(col & 'hF), 1'b0);
            push_write(KIND_CMD, HIGH_COL_CMD + 8'(col >> 4), 1'b0);
        endfunction

        // Applies one accepted item to the shadow buffer and queues its writes.
        function void apply_item(logic [1:0] func, logic [7:0] x, logic [7:0] y,
                                 logic color, logic [2:0] tpage, logic [1:0] tcol);
            int         page;
            int         idx;
            int         start;
            logic [7:0] mask;
            case (func)
                FUNC_DRAW: begin
                    // Pixels off the panel are dropped without a trace.
                    if (int'(x) < COLS && int'(y) < 8 * PAGES) begin
                        page = int'(y) >> 3;
                        mask = 8'h01 << y[2:0];
                        idx  = page * COLS + int'(x);
                        if (color) begin
                            shadow[idx] = shadow[idx] | mask;
                        end else begin
                            shadow[idx] = shadow[idx] & ~mask;
                        end
                        if (incremental) begin
                            push_address(page, int'(x));
                            push_write(KIND_DATA, shadow[idx], 1'b1);
                        end
                    end
                end
                FUNC_FILL: begin
                    foreach (shadow[i]) shadow[i] = color ? FILL_ONES : FILL_ZEROS;
                end
                FUNC_TILE: begin
                    start = int'(tcol) * TILE;
                    if (int'(tpage) < PAGES && start + TILE <= COLS) begin
                        push_address(int'(tpage), start);
                        for (int i = 0; i < TILE; i++) begin
                            push_write(KIND_DATA, shadow[int'(tpage) * COLS + start + i],
                                       i == TILE - 1);
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        // Compares one observed bus write against the oldest one owed.
        function void check_write(logic kind, logic [7:0] value, logic last);
            t_result w;
            if (pending_writes.size() == 0) begin
                errors++;
                $display("%0t: unexpected write, expected none, %s %0d value 0x%02h last %0d",
                         $time, "actual kind", kind, value, last);
                return;
            end
            w = pending_writes.pop_front();
            checked++;
            if (kind !== w.kind) begin
                errors++;
                $display("%0t: kind mismatch, expected %0d actual %0d", $time, w.kind, kind);
            end
            if (value !== w.value) begin
                errors++;
                $display("%0t: value mismatch, expected 0x%02h actual 0x%02h",
                         $time, w.value, value);
            end
            if (last !== w.last) begin
                errors++;
                $display("%0t: last mismatch, expected %0d actual %0d", $time, w.last, last);
            end
        endfunction
    endclass

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic       i_cfg_wr_data = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [1:0] i_func        = FUNC_DRAW;
    logic [7:0] i_pos_x       = 8'd0;
    logic [7:0] i_pos_y       = 8'd0;
    logic       i_color       = 1'b0;
    logic [2:0] i_tile_page   = 3'd0;
    logic [1:0] i_tile_column = 2'd0;
    logic       i_out_stall   = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_kind;
    logic [7:0] o_value;
    logic       o_last;

    panel_write_board board = new();
    bit               steady = 1'b0;
    int               n_items = 0;
    int               n_tiles = 0;
    int               n_fills = 0;
    int               cycles  = 0;

    page_framebuffer_pixel_engine_core #(
        .PANEL_COLUMNS(COLS),
        .PANEL_PAGES  (PAGES),
        .TILE_COLUMNS (TILE)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_color      (i_color),
        .i_tile_page  (i_tile_page),
        .i_tile_column(i_tile_column),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_value      (o_value),
        .o_last       (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // The receiver stalls at random except during the steady stretch.
    always @(negedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99) < 17);
    end

    // Every output transfer is checked at the edge that completes it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_write(o_kind, o_value, o_last);
        end
    end

    // Run guard against a hung handshake.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timed out with %0d writes still owed", $time,
                     board.pending_writes.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offers one item and returns at the falling edge after its transfer.
    task automatic send_item(input logic [1:0] func, input logic [7:0] x, input logic [7:0] y,
                             input logic color, input logic [2:0] tpage,
                             input logic [1:0] tcol);
        while (!steady && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= func;
        i_pos_x       <= x;
        i_pos_y       <= y;
        i_color       <= color;
        i_tile_page   <= tpage;
        i_tile_column <= tcol;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.apply_item(func, x, y, color, tpage, tcol);
        n_items++;
        if (func == FUNC_TILE) n_tiles++;
        if (func == FUNC_FILL) n_fills++;
        @(negedge i_clk);
    endtask

    task automatic draw(input logic [7:0] x, input logic [7:0] y, input logic color);
        send_item(FUNC_DRAW, x, y, color, 3'($urandom), 2'($urandom));
    endtask

    task automatic tile(input logic [2:0] tpage, input logic [1:0] tcol);
        send_item(FUNC_TILE, 8'($urandom), 8'($urandom), 1'($urandom), tpage, tcol);
    endtask

    task automatic fill(input logic color);
        send_item(FUNC_FILL, 8'($urandom), 8'($urandom), color, 3'($urandom), 2'($urandom));
    endtask

    // Holds the sender back until every owed write has arrived.
    task automatic drain_writes();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (board.pending_writes.size() != 0);
    endtask

    // Changes the update mode once the block has gone quiet.
    task automatic write_incremental(input logic mode);
        drain_writes();
        repeat (QUIET_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        board.incremental = mode;
    endtask

    // Mostly on-panel draws and tile refreshes, with some fills, clipped and unused items.
    task automatic send_random(inout int useful);
        logic [1:0] func;
        logic [7:0] x;
        logic [7:0] y;
        logic       color;
        logic [2:0] tpage;
        logic [1:0] tcol;
        int         pick;
        pick  = $urandom_range(99);
        x     = 8'($urandom);
        y     = 8'($urandom);
        color = 1'($urandom);
        tpage = 3'($urandom);
        tcol  = 2'($urandom);
        if (pick < 62) begin
            func = FUNC_DRAW;
            // Half the draws land in the corner that tile refreshes often read back.
            if ($urandom_range(99) < 50) begin
                x = 8'($urandom_range(63));
                y = 8'($urandom_range(15));
            end else begin
                x = 8'($urandom_range(COLS - 1));
                y = 8'($urandom_range(8 * PAGES - 1));
            end
            useful++;
        end else if (pick < 82) begin
            func = FUNC_TILE;
            useful++;
        end else if (pick < 86) begin
            func = FUNC_FILL;
            useful++;
        end else if (pick < 93) begin
            func = FUNC_UNUSED;
        end else begin
            // A draw that is always clipped on one axis or both.
            func = FUNC_DRAW;
            if (int'(x) < COLS) y = 8'($urandom_range(255, 8 * PAGES));
        end
        send_item(func, x, y, color, tpage, tcol);
    endtask

    initial begin
        int  useful;
        bit  paused;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corners, clipping, unused code, fills and tile refreshes.
        write_incremental(1'b1);
        draw(8'd0, 8'd0, 1'b1);
        draw(8'd127, 8'd63, 1'b1);
        draw(8'd128, 8'd5, 1'b1);
        draw(8'd5, 8'd64, 1'b1);
        draw(8'd255, 8'd255, 1'b0);
        draw(8'd127, 8'd63, 1'b0);
        draw(8'd3, 8'd9, 1'b1);
        tile(3'd0, 2'd0);
        tile(3'd7, 2'd3);
        send_item(FUNC_UNUSED, 8'($urandom), 8'($urandom), 1'b1, 3'd7, 2'd3);
        fill(1'b1);
        draw(8'd64, 8'd31, 1'b0);
        tile(3'd3, 2'd2);
        fill(1'b0);
        draw(8'd100, 8'd7, 1'b1);

        // Directed: buffer-only draws become visible through a refresh.
        write_incremental(1'b0);
        draw(8'd10, 8'd10, 1'b1);
        draw(8'd200, 8'd20, 1'b1);
        draw(8'd11, 8'd10, 1'b1);
        draw(8'd10, 8'd10, 1'b0);
        tile(3'd1, 2'd0);

        // Random with immediate updates, a steady stretch and one full drain.
        write_incremental(1'b1);
        useful = 0;
        paused = 1'b0;
        while (useful < 50) begin
            steady <= (useful >= 15 && useful < 35);
            if (useful == 40 && !paused) begin
                drain_writes();
                paused = 1'b1;
            end
            send_random(useful);
        end
        steady <= 1'b0;

        // Random with buffer-only draws.
        write_incremental(1'b0);
        useful = 0;
        while (useful < 20) send_random(useful);

        // Random with immediate updates again.
        write_incremental(1'b1);
        useful = 0;
        while (useful < 25) send_random(useful);

        drain_writes();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("Sent %0d items (%0d tile refreshes, %0d fills), checked %0d panel writes.",
                 n_items, n_tiles, n_fills, board.checked);
        $display("Both update modes ran with random gaps on each side and one steady stretch.");
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
